[rtl/mpm_pkg.sv]
package mpm_pkg;

   localparam int NODES_DEFAULT       = 256;
   localparam int MAX_DEPTH_DEFAULT   = 32;
   localparam int SYMBOL_BITS_DEFAULT = 8;
   localparam int MAX_RESULTS         = 32;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_SCAN  = 2'd2;
   localparam logic [1:0] KIND_RESET = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic       word_end;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_start;
      logic [5:0]  match_length;
      logic [7:0]  match_node;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RESP,
      S_F_LOOP,
      S_F_CHK,
      S_ADD_RD,
      S_ADD_GOT,
      S_ADD_FD,
      S_ADD_LINK,
      S_ADD_END,
      S_ADD_MARK,
      S_SC_RD,
      S_SC_GOT,
      S_SC_FD,
      S_SC_OUT,
      S_SC_OGOT,
      S_SC_MRD,
      S_SC_EMIT,
      S_BD_ENQ,
      S_BD_ENQW,
      S_BD_HEAD,
      S_BD_QW,
      S_BD_VGOT,
      S_BD_PGOT,
      S_BD_XRD,
      S_BD_XGOT,
      S_BD_XFD,
      S_BD_URD,
      S_BD_UGOT
   } state_type;

endpackage

[rtl/multi_pattern_matcher_core.sv]
// Aho-Corasick keyword matcher built around one node memory and one queue
// memory, both single ported with a registered read. The engine takes one
// item at a time and works through it in steps of at most one access to the
// node memory each, so the time that an item takes depends on the data. A
// reset scan clears the scan state and returns its result. Adding a symbol
// reads the cursor node, compares its children one at a time, then moves to
// the matching child, makes a new node or refuses the symbol, and marks a
// word end if asked; a symbol of an already spoiled pattern skips straight
// to the end. A scan walks the suffix chain, reading each node and comparing
// its children, then returns one empty result when nothing matches or one
// result per reported match. A link build visits the nodes in queue order,
// and each node below the first level also takes a suffix walk as in a scan.
// Results leave through an output register, so each result appears in the
// cycle after the engine hands it over and may wait there while the engine
// works on the next; a stalled result register holds the engine back.
module multi_pattern_matcher_core #(
   parameter int NODES       = mpm_pkg::NODES_DEFAULT,
   parameter int MAX_DEPTH   = mpm_pkg::MAX_DEPTH_DEFAULT,
   parameter int SYMBOL_BITS = mpm_pkg::SYMBOL_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mpm_pkg::rsp_type rsp_data
);

   logic             eng_ready, res_valid, res_ready;
   mpm_pkg::rsp_type res_data;
   logic             rsp_valid_ff, rsp_valid_in;
   mpm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   mpm_engine #(
      .NODES(NODES), .MAX_DEPTH(MAX_DEPTH), .SYMBOL_BITS(SYMBOL_BITS)
   ) u_engine (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(eng_ready), .req_data(req_data),
      .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
   );

   assign req_stall = !eng_ready;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/mpm_ram.sv]
module mpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/mpm_engine.sv]
module mpm_engine #(
   parameter int NODES       = mpm_pkg::NODES_DEFAULT,
   parameter int MAX_DEPTH   = mpm_pkg::MAX_DEPTH_DEFAULT,
   parameter int SYMBOL_BITS = mpm_pkg::SYMBOL_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpm_pkg::req_type req_data,
   output logic             res_valid,
   input  logic             res_ready,
   output mpm_pkg::rsp_type res_data
);

   localparam int IW = $clog2(NODES);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int SB = SYMBOL_BITS;
   localparam int KW = $clog2(mpm_pkg::MAX_RESULTS);
   localparam logic [IW:0]   CNT_FULL  = (IW + 1)'(NODES);
   localparam logic [DW:0]   DEPTH_MAX = (DW + 1)'(MAX_DEPTH);
   localparam logic [KW-1:0] K_LAST    = KW'(mpm_pkg::MAX_RESULTS - 1);

   typedef struct packed {
      logic [IW-1:0] parent;
      logic [SB-1:0] symbol;
      logic          is_end;
      logic [DW-1:0] depth;
      logic [IW-1:0] first_child;
      logic [IW-1:0] next_sibling;
      logic [IW-1:0] suffix;
      logic [IW-1:0] out_link;
   } node_type;

   localparam int NW = $bits(node_type);

   mpm_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0]    kind_ff, kind_in;
   logic          end_ff, end_in;
   logic [SB-1:0] skey_ff, skey_in;
   logic [1:0]    status_ff, status_in, err_ff, err_in;
   logic [IW-1:0] cursor_ff, cursor_in, cur_ff, cur_in;
   logic [IW:0]   cnt_ff, cnt_in;
   logic [31:0]   pos_ff, pos_in;
   logic [IW-1:0] n_ff, n_in, c_ff, c_in, m_ff, m_in, v_ff, v_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [KW-1:0] k_ff, k_in;
   node_type      nrec_ff, nrec_in, vrec_ff, vrec_in;
   logic [IW-1:0] root_fc_ff, root_fc_in;
   logic          rd_root_ff;

   logic          nd_we, nd_re, q_we, q_re;
   logic [IW-1:0] nd_addr, q_addr, q_wdata, q_rdata;
   node_type      nd_wdata, nd_rdata, rec_rd, root_rec;
   logic [SB-1:0] sym_masked;
   logic [IW-1:0] m_pick;
   logic          depth_ovf, emit_last;
   logic [SB+7:0] sym_ext;
   logic [DW+5:0] len_ext;
   logic [IW+7:0] node_ext;

   mpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .we(nd_we), .re(nd_re), .addr(nd_addr),
      .wdata(nd_wdata), .rdata(nd_rdata)
   );

   mpm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_queue_ram (
      .clock(clock), .we(q_we), .re(q_re), .addr(q_addr),
      .wdata(q_wdata), .rdata(q_rdata)
   );

   // The root is kept in registers; a read of node zero returns this record.
   always_comb begin
      root_rec             = '0;
      root_rec.first_child = root_fc_ff;
   end

   assign rec_rd     = rd_root_ff ? root_rec : nd_rdata;
   assign sym_ext    = {8'd0, req_data.symbol};
   assign sym_masked = sym_ext[SB-1:0];
   assign m_pick     = rec_rd.is_end ? n_ff : rec_rd.out_link;
   assign depth_ovf  = ({1'b0, nrec_ff.depth} + 1'b1) > DEPTH_MAX;
   assign emit_last  = (rec_rd.out_link == '0) || (k_ff == K_LAST);
   assign len_ext    = {6'd0, rec_rd.depth};
   assign node_ext   = {8'd0, m_ff};
   assign req_ready  = (state_ff == mpm_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpm_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.kind)
                  mpm_pkg::KIND_ADD:
                     state_in = (err_ff != mpm_pkg::ST_OK) ? mpm_pkg::S_ADD_END
                                                         : mpm_pkg::S_ADD_RD;
                  mpm_pkg::KIND_BUILD: state_in = mpm_pkg::S_BD_ENQ;
                  mpm_pkg::KIND_SCAN:  state_in = mpm_pkg::S_SC_RD;
                  default:             state_in = mpm_pkg::S_RESP;
               endcase
            end
         end
         mpm_pkg::S_RESP:     if (res_ready) state_in = mpm_pkg::S_IDLE;
         mpm_pkg::S_F_LOOP:   state_in = (c_ff == '0) ? ret_ff : mpm_pkg::S_F_CHK;
         mpm_pkg::S_F_CHK:
            state_in = (rec_rd.symbol == skey_ff) ? ret_ff : mpm_pkg::S_F_LOOP;
         mpm_pkg::S_ADD_RD:   state_in = mpm_pkg::S_ADD_GOT;
         mpm_pkg::S_ADD_GOT:  state_in = mpm_pkg::S_F_LOOP;
         mpm_pkg::S_ADD_FD:
            state_in = (c_ff != '0 || depth_ovf || cnt_ff >= CNT_FULL)
                       ? mpm_pkg::S_ADD_END : mpm_pkg::S_ADD_LINK;
         mpm_pkg::S_ADD_LINK: state_in = mpm_pkg::S_ADD_END;
         mpm_pkg::S_ADD_END:
            state_in = (end_ff && err_ff == mpm_pkg::ST_OK && cursor_ff != '0)
                       ? mpm_pkg::S_ADD_MARK : mpm_pkg::S_RESP;
         mpm_pkg::S_ADD_MARK: state_in = mpm_pkg::S_RESP;
         mpm_pkg::S_SC_RD:    state_in = mpm_pkg::S_SC_GOT;
         mpm_pkg::S_SC_GOT:   state_in = mpm_pkg::S_F_LOOP;
         mpm_pkg::S_SC_FD:
            state_in = (c_ff != '0 || n_ff == '0) ? mpm_pkg::S_SC_OUT
                                                  : mpm_pkg::S_SC_RD;
         mpm_pkg::S_SC_OUT:   state_in = mpm_pkg::S_SC_OGOT;
         mpm_pkg::S_SC_OGOT:
            state_in = (m_pick != '0) ? mpm_pkg::S_SC_MRD : mpm_pkg::S_RESP;
         mpm_pkg::S_SC_MRD:   state_in = mpm_pkg::S_SC_EMIT;
         mpm_pkg::S_SC_EMIT: begin
            if (res_ready) begin
               state_in = emit_last ? mpm_pkg::S_IDLE : mpm_pkg::S_SC_MRD;
            end
         end
         mpm_pkg::S_BD_ENQ:
            state_in = (c_ff != '0) ? mpm_pkg::S_BD_ENQW : mpm_pkg::S_BD_HEAD;
         mpm_pkg::S_BD_ENQW:  state_in = mpm_pkg::S_BD_ENQ;
         mpm_pkg::S_BD_HEAD:
            state_in = (head_ff == tail_ff) ? mpm_pkg::S_RESP : mpm_pkg::S_BD_QW;
         mpm_pkg::S_BD_QW:    state_in = mpm_pkg::S_BD_VGOT;
         mpm_pkg::S_BD_VGOT:
            state_in = (rec_rd.parent == '0) ? mpm_pkg::S_BD_URD : mpm_pkg::S_BD_PGOT;
         mpm_pkg::S_BD_PGOT:  state_in = mpm_pkg::S_BD_XRD;
         mpm_pkg::S_BD_XRD:   state_in = mpm_pkg::S_BD_XGOT;
         mpm_pkg::S_BD_XGOT:  state_in = mpm_pkg::S_F_LOOP;
         mpm_pkg::S_BD_XFD:
            state_in = (c_ff != '0 || n_ff == '0) ? mpm_pkg::S_BD_URD
                                                  : mpm_pkg::S_BD_XRD;
         mpm_pkg::S_BD_URD:   state_in = mpm_pkg::S_BD_UGOT;
         mpm_pkg::S_BD_UGOT:  state_in = mpm_pkg::S_BD_ENQ;
         default:             state_in = mpm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ret_in     = ret_ff;
      kind_in    = kind_ff;
      end_in     = end_ff;
      skey_in    = skey_ff;
      status_in  = status_ff;
      err_in     = err_ff;
      cursor_in  = cursor_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      n_in       = n_ff;
      c_in       = c_ff;
      m_in       = m_ff;
      v_in       = v_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      k_in       = k_ff;
      nrec_in    = nrec_ff;
      vrec_in    = vrec_ff;
      nd_we      = 1'b0;
      nd_re      = 1'b0;
      nd_addr    = '0;
      nd_wdata   = rec_rd;
      q_we       = 1'b0;
      q_re       = 1'b0;
      q_addr     = '0;
      q_wdata    = c_ff;
      res_valid  = 1'b0;
      res_data   = '0;
      res_data.last   = 1'b1;
      res_data.status = status_ff;

      unique case (state_ff)
         mpm_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               end_in    = req_data.word_end;
               skey_in   = sym_masked;
               status_in = mpm_pkg::ST_OK;
               unique case (req_data.kind)
                  mpm_pkg::KIND_ADD:   status_in = err_ff;
                  mpm_pkg::KIND_BUILD: begin
                     head_in = '0;
                     tail_in = '0;
                     c_in    = root_fc_ff;
                  end
                  mpm_pkg::KIND_SCAN:  n_in = cur_ff;
                  default: begin
                     cur_in = '0;
                     pos_in = '0;
                  end
               endcase
            end
         end
         mpm_pkg::S_RESP: begin
            res_valid = 1'b1;
            if (res_ready && kind_ff == mpm_pkg::KIND_SCAN) begin
               pos_in = pos_ff + 32'd1;
            end
         end
         mpm_pkg::S_F_LOOP: begin
            nd_re   = (c_ff != '0);
            nd_addr = c_ff;
         end
         mpm_pkg::S_F_CHK: begin
            if (rec_rd.symbol != skey_ff) begin
               c_in = rec_rd.next_sibling;
            end
         end
         mpm_pkg::S_ADD_RD: begin
            nd_re   = 1'b1;
            nd_addr = cursor_ff;
         end
         mpm_pkg::S_ADD_GOT: begin
            nrec_in = rec_rd;
            c_in    = rec_rd.first_child;
            ret_in  = mpm_pkg::S_ADD_FD;
         end
         mpm_pkg::S_ADD_FD: begin
            if (c_ff != '0) begin
               cursor_in = c_ff;
            end else if (depth_ovf) begin
               status_in = mpm_pkg::ST_LONG;
               err_in    = mpm_pkg::ST_LONG;
            end else if (cnt_ff >= CNT_FULL) begin
               status_in = mpm_pkg::ST_FULL;
               err_in    = mpm_pkg::ST_FULL;
            end else begin
               nd_we                 = 1'b1;
               nd_addr               = cnt_ff[IW-1:0];
               nd_wdata.parent       = cursor_ff;
               nd_wdata.symbol       = skey_ff;
               nd_wdata.is_end       = 1'b0;
               nd_wdata.depth        = nrec_ff.depth + 1'b1;
               nd_wdata.first_child  = '0;
               nd_wdata.next_sibling = nrec_ff.first_child;
               nd_wdata.suffix       = '0;
               nd_wdata.out_link     = '0;
            end
         end
         mpm_pkg::S_ADD_LINK: begin
            nd_we                = 1'b1;
            nd_addr              = cursor_ff;
            nd_wdata             = nrec_ff;
            nd_wdata.first_child = cnt_ff[IW-1:0];
            cursor_in            = cnt_ff[IW-1:0];
            cnt_in               = cnt_ff + 1'b1;
         end
         mpm_pkg::S_ADD_END: begin
            if (end_ff) begin
               if (err_ff == mpm_pkg::ST_OK && cursor_ff != '0) begin
                  nd_re   = 1'b1;
                  nd_addr = cursor_ff;
               end else begin
                  cursor_in = '0;
                  err_in    = mpm_pkg::ST_OK;
               end
            end
         end
         mpm_pkg::S_ADD_MARK: begin
            nd_we           = 1'b1;
            nd_addr         = cursor_ff;
            nd_wdata        = rec_rd;
            nd_wdata.is_end = 1'b1;
            cursor_in       = '0;
            err_in          = mpm_pkg::ST_OK;
         end
         mpm_pkg::S_SC_RD: begin
            nd_re   = 1'b1;
            nd_addr = n_ff;
         end
         mpm_pkg::S_SC_GOT: begin
            nrec_in = rec_rd;
            c_in    = rec_rd.first_child;
            ret_in  = mpm_pkg::S_SC_FD;
         end
         mpm_pkg::S_SC_FD: begin
            if (c_ff != '0) begin
               n_in = c_ff;
            end else if (n_ff != '0) begin
               n_in = nrec_ff.suffix;
            end
         end
         mpm_pkg::S_SC_OUT: begin
            cur_in  = n_ff;
            nd_re   = 1'b1;
            nd_addr = n_ff;
         end
         mpm_pkg::S_SC_OGOT: begin
            m_in = m_pick;
            k_in = '0;
         end
         mpm_pkg::S_SC_MRD: begin
            nd_re   = 1'b1;
            nd_addr = m_ff;
         end
         mpm_pkg::S_SC_EMIT: begin
            res_valid             = 1'b1;
            res_data.found        = 1'b1;
            res_data.match_start  = pos_ff - 32'(rec_rd.depth) + 32'd1;
            res_data.match_length = len_ext[5:0];
            res_data.match_node   = node_ext[7:0];
            res_data.last         = emit_last;
            res_data.status       = mpm_pkg::ST_OK;
            if (res_ready) begin
               if (emit_last) begin
                  pos_in = pos_ff + 32'd1;
               end else begin
                  m_in = rec_rd.out_link;
                  k_in = k_ff + 1'b1;
               end
            end
         end
         mpm_pkg::S_BD_ENQ: begin
            if (c_ff != '0) begin
               q_we    = 1'b1;
               q_addr  = tail_ff;
               tail_in = tail_ff + 1'b1;
               nd_re   = 1'b1;
               nd_addr = c_ff;
            end
         end
         mpm_pkg::S_BD_ENQW: c_in = rec_rd.next_sibling;
         mpm_pkg::S_BD_HEAD: begin
            if (head_ff != tail_ff) begin
               q_re    = 1'b1;
               q_addr  = head_ff;
               head_in = head_ff + 1'b1;
            end
         end
         mpm_pkg::S_BD_QW: begin
            v_in    = q_rdata;
            nd_re   = 1'b1;
            nd_addr = q_rdata;
         end
         mpm_pkg::S_BD_VGOT: begin
            vrec_in = rec_rd;
            skey_in = rec_rd.symbol;
            if (rec_rd.parent == '0) begin
               c_in = '0;
            end else begin
               nd_re   = 1'b1;
               nd_addr = rec_rd.parent;
            end
         end
         mpm_pkg::S_BD_PGOT: n_in = rec_rd.suffix;
         mpm_pkg::S_BD_XRD: begin
            nd_re   = 1'b1;
            nd_addr = n_ff;
         end
         mpm_pkg::S_BD_XGOT: begin
            nrec_in = rec_rd;
            c_in    = rec_rd.first_child;
            ret_in  = mpm_pkg::S_BD_XFD;
         end
         mpm_pkg::S_BD_XFD: begin
            if (c_ff == '0 && n_ff != '0) begin
               n_in = nrec_ff.suffix;
            end
         end
         mpm_pkg::S_BD_URD: begin
            nd_re   = 1'b1;
            nd_addr = c_ff;
         end
         mpm_pkg::S_BD_UGOT: begin
            nd_we             = 1'b1;
            nd_addr           = v_ff;
            nd_wdata          = vrec_ff;
            nd_wdata.suffix   = c_ff;
            nd_wdata.out_link = rec_rd.is_end ? c_ff : rec_rd.out_link;
            c_in              = vrec_ff.first_child;
         end
         default: begin
         end
      endcase
   end

   // Writes to node zero also land in the root register, which keeps their first child.
   assign root_fc_in = (nd_we && nd_addr == '0) ? nd_wdata.first_child : root_fc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mpm_pkg::S_IDLE;
         ret_ff     <= mpm_pkg::S_IDLE;
         err_ff     <= mpm_pkg::ST_OK;
         cursor_ff  <= '0;
         cur_ff     <= '0;
         cnt_ff     <= (IW + 1)'(1);
         pos_ff     <= '0;
         root_fc_ff <= '0;
         rd_root_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         err_ff     <= err_in;
         cursor_ff  <= cursor_in;
         cur_ff     <= cur_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         root_fc_ff <= root_fc_in;
         if (nd_re) begin
            rd_root_ff <= (nd_addr == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      end_ff    <= end_in;
      skey_ff   <= skey_in;
      status_ff <= status_in;
      n_ff      <= n_in;
      c_ff      <= c_in;
      m_ff      <= m_in;
      v_ff      <= v_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      k_ff      <= k_in;
      nrec_ff   <= nrec_in;
      vrec_ff   <= vrec_in;
   end

endmodule

[rtl/mpm_checker.sv]
module mpm_assert_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input mpm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mpm_pkg::rsp_type rsp_data
);

   // A stalled request transfer must hold.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // A stalled result transfer must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.last && rsp_data.match_start == 32'd0 &&
         rsp_data.match_length == 6'd0 && rsp_data.match_node == 8'd0)
      else $error("empty result carries match data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         rsp_data.status == mpm_pkg::ST_OK && rsp_data.match_node != 8'd0)
      else $error("match result with bad status or root node");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mpm_pkg::ST_FULL ||
                    rsp_data.status == mpm_pkg::ST_LONG) |->
         !rsp_data.found && rsp_data.last)
      else $error("error status on a match result");

endmodule

bind multi_pattern_matcher_core mpm_assert_checker u_mpm_assert_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
